/* hw/rtl/ecpi_pkg.sv */
package ecpi_pkg;

    localparam int COLOR_W   = 24;
    localparam int OUT_IDX_W = 8;
    localparam int OUT_CNT_W = 9;

    // Control flags that travel with a pixel down the cell chain
    typedef struct packed {
        logic valid;   // stage holds a pixel
        logic last;    // final pixel of the image
        logic found;   // color already placed (hit or claim upstream)
        logic added;   // this pixel claimed a free cell
    } ctl_t;

endpackage

/* hw/rtl/ecpi_cell.sv */
module ecpi_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  ecpi_pkg::ctl_t              in_ctl,
    input  logic [ecpi_pkg::COLOR_W-1:0] in_color,
    input  logic [IDX_W-1:0]            in_idx,
    input  logic [CNT_W-1:0]            in_cnt,
    output ecpi_pkg::ctl_t              out_ctl,
    output logic [ecpi_pkg::COLOR_W-1:0] out_color,
    output logic [IDX_W-1:0]            out_idx,
    output logic [CNT_W-1:0]            out_cnt
);
    import ecpi_pkg::*;

    // palette entry held by this cell; used_reg is this cell's bit of the fill count
    logic [COLOR_W-1:0] entry_reg;
    logic               used_reg;
    logic               used_next;

    ctl_t               ctl_reg;
    ctl_t               ctl_next;
    logic [COLOR_W-1:0] color_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    logic searching;
    logic hit;
    logic claim;

    always_comb
    begin
        searching = in_ctl.valid && !in_ctl.found;
        hit       = searching && used_reg && (entry_reg == in_color);
        claim     = searching && !used_reg;

        ctl_next       = in_ctl;
        ctl_next.found = in_ctl.found | hit | claim;
        ctl_next.added = in_ctl.added | claim;
        idx_next       = (hit || claim) ? IDX_W'(CELL_IDX) : in_idx;
        cnt_next       = in_cnt + CNT_W'(used_reg | claim);

        used_next = used_reg;
        if (in_ctl.valid && in_ctl.last)
        begin
            used_next = 1'b0;     // image ends: entry frees after the last pixel passes
        end
        else if (claim)
        begin
            used_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            ctl_reg  <= '0;
        end
        else if (en)
        begin
            used_reg <= used_next;
            ctl_reg  <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (claim)
            begin
                entry_reg <= in_color;
            end
            color_reg <= in_color;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign out_ctl   = ctl_reg;
    assign out_color = color_reg;
    assign out_idx   = idx_reg;
    assign out_cnt   = cnt_reg;

endmodule

/* hw/rtl/exact_color_palette_indexer_top.sv */
// Each input transfer steps through the palette cells in order to its result on the master side.
// Throughput: one pixel per cycle; each pixel steps through one palette cell per cycle.
// A stall on the master side freezes the whole cell chain.
// Reset (rst_n, async, active low) empties the palette, drops all pixels in flight and
// clears the overflow flag; the palette also clears after each pixel marked tlast.
module exact_color_palette_indexer_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side: pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        s_tlast,   // last_pixel
    // master side: results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] pixel_index, [8] is_new_color, [9] overflow,
                                   // [18:10] color_count, [23:19] zero
    output logic        m_tlast    // image_done
);
    import ecpi_pkg::*;

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

    // Chain stage k is the input of cell k; stage PALETTE_ENTRIES is the chain output.
    ctl_t               ctl   [0:PALETTE_ENTRIES];
    logic [COLOR_W-1:0] color [0:PALETTE_ENTRIES];
    logic [IDX_W-1:0]   idx   [0:PALETTE_ENTRIES];
    logic [CNT_W-1:0]   cnt   [0:PALETTE_ENTRIES];

    ctl_t head_ctl;
    logic en;
    logic overflow_seen_reg;
    logic overflow_seen_next;
    logic miss;

    logic [OUT_IDX_W-1:0] out_index;
    logic [OUT_CNT_W-1:0] out_count;

    // Whole chain advances unless a finished result is waiting on the master side.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Control flags of an incoming pixel: nothing placed yet.
    always_comb
    begin
        head_ctl       = '0;
        head_ctl.valid = s_tvalid;
        head_ctl.last  = s_tlast;
    end

    assign ctl[0]   = head_ctl;
    assign color[0] = s_tdata;
    assign idx[0]   = '0;
    assign cnt[0]   = '0;

    // Each cell holds one palette entry in first-seen order. A pixel matches the
    // first cell holding its color or claims the first free cell; counting used
    // cells along the way gives the fill count after this pixel.
    for (genvar k = 0; k < PALETTE_ENTRIES; k++)
    begin : g_cell
        ecpi_cell #(
            .CELL_IDX (k),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_ctl    (ctl[k]),
            .in_color  (color[k]),
            .in_idx    (idx[k]),
            .in_cnt    (cnt[k]),
            .out_ctl   (ctl[k+1]),
            .out_color (color[k+1]),
            .out_idx   (idx[k+1]),
            .out_cnt   (cnt[k+1])
        );
    end

    // A pixel leaving the chain unplaced found the palette full: index 0, overflow.
    assign miss = !ctl[PALETTE_ENTRIES].found;

    always_comb
    begin
        overflow_seen_next = overflow_seen_reg;
        if (m_tvalid && m_tready)
        begin
            if (ctl[PALETTE_ENTRIES].last)
            begin
                overflow_seen_next = 1'b0;
            end
            else if (miss)
            begin
                overflow_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overflow_seen_reg <= 1'b0;
        end
        else
        begin
            overflow_seen_reg <= overflow_seen_next;
        end
    end

    // Fit internal index and count to the output field widths.
    if (IDX_W >= OUT_IDX_W)
    begin : g_idx_trunc
        assign out_index = idx[PALETTE_ENTRIES][OUT_IDX_W-1:0];
    end
    else
    begin : g_idx_ext
        assign out_index = {{(OUT_IDX_W-IDX_W){1'b0}}, idx[PALETTE_ENTRIES]};
    end

    if (CNT_W >= OUT_CNT_W)
    begin : g_cnt_trunc
        assign out_count = cnt[PALETTE_ENTRIES][OUT_CNT_W-1:0];
    end
    else
    begin : g_cnt_ext
        assign out_count = {{(OUT_CNT_W-CNT_W){1'b0}}, cnt[PALETTE_ENTRIES]};
    end

    assign m_tvalid = ctl[PALETTE_ENTRIES].valid;
    assign m_tlast  = ctl[PALETTE_ENTRIES].last;
    assign m_tdata  = {5'b0,
                       out_count,
                       overflow_seen_reg | miss,
                       ctl[PALETTE_ENTRIES].added,
                       out_index};

endmodule

/* tb/exact_color_palette_indexer_top_test.sv */
`timescale 1ns / 100ps

import ecpi_pkg::*;

typedef struct {
    logic [OUT_IDX_W-1:0] pixel_index;
    logic                 is_new_color;
    logic                 overflow;
    logic [OUT_CNT_W-1:0] color_count;
    logic                 image_done;
} palette_result_t;

// Tracks the palette of the current image and the results owed for every pixel taken in.
class palette_scoreboard;
    logic [COLOR_W-1:0] colors[];
    int unsigned        depth;
    int unsigned        fill;
    bit                 overflow_seen;
    palette_result_t    expected_results[$];
    int unsigned        results_seen;

    function new(int unsigned entries);
        depth         = entries;
        colors        = new[entries];
        fill          = 0;
        overflow_seen = 1'b0;
        results_seen  = 0;
    endfunction

    // Looks the color up in first-seen order, appends it while there is room.
    function void index_pixel(logic [COLOR_W-1:0] rgb, logic last);
        palette_result_t r;
        int unsigned     i;
        int unsigned     idx;
        bit              hit;
        hit            = 1'b0;
        idx            = 0;
        r.is_new_color = 1'b0;
        for (i = 0; i < fill; i++) begin
            if (!hit && colors[i] == rgb) begin
                hit = 1'b1;
                idx = i;
            end
        end
        if (!hit) begin
            if (fill < depth) begin
                colors[fill]   = rgb;
                idx            = fill;
                fill++;
                r.is_new_color = 1'b1;
            end
            else begin
                overflow_seen = 1'b1;
                idx           = 0;
            end
        end
        r.pixel_index = OUT_IDX_W'(idx);
        r.overflow    = overflow_seen;
        r.color_count = OUT_CNT_W'(fill);
        r.image_done  = last;
        expected_results.push_back(r);
        // end of image: palette and flag start over
        if (last) begin
            fill          = 0;
            overflow_seen = 1'b0;
        end
    endfunction

    // Returns an empty string on a match, else one line naming the bad fields.
    function string match_result(palette_result_t got);
        palette_result_t want;
        string           msg;
        results_seen++;
        if (expected_results.size() == 0)
            return $sformatf("result %0d arrived with no pixel pending", results_seen);
        want = expected_results.pop_front();
        msg  = "";
        if (got.pixel_index !== want.pixel_index)
            msg = {msg, $sformatf(" index %0d exp %0d", got.pixel_index, want.pixel_index)};
        if (got.is_new_color !== want.is_new_color)
            msg = {msg, $sformatf(" new %b exp %b", got.is_new_color, want.is_new_color)};
        if (got.overflow !== want.overflow)
            msg = {msg, $sformatf(" overflow %b exp %b", got.overflow, want.overflow)};
        if (got.color_count !== want.color_count)
            msg = {msg, $sformatf(" count %0d exp %0d", got.color_count, want.color_count)};
        if (got.image_done !== want.image_done)
            msg = {msg, $sformatf(" tlast %b exp %b", got.image_done, want.image_done)};
        if (msg != "")
            msg = {$sformatf("result %0d:", results_seen), msg};
        return msg;
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction
endclass

module exact_color_palette_indexer_top_test;

    localparam int PALETTE_ENTRIES = 256;
    // long receiver hold-off, well past the depth of the cell chain
    localparam int LONG_HOLD       = 700;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] red, [15:8] green, [23:16] blue
    logic        s_tlast;   // last_pixel
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] index, [8] new, [9] overflow, [18:10] count, [23:19] zero
    logic        m_tlast;   // image_done

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int unsigned mismatch_count = 0;

    palette_scoreboard palette_sb = new(PALETTE_ENTRIES);

    exact_color_palette_indexer_top #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("exact_color_palette_indexer_top test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Receiver: random stalls per phase; a hold request parks tready low until the LONG_HOLD countdown runs out.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Both sides sampled at the rising edge, before the block's registers move.
    always @(posedge clk)
    begin
        palette_result_t got;
        string           msg;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                palette_sb.index_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.pixel_index  = m_tdata[7:0];
                got.is_new_color = m_tdata[8];
                got.overflow     = m_tdata[9];
                got.color_count  = m_tdata[18:10];
                got.image_done   = m_tlast;
                msg = palette_sb.match_result(got);
                if (msg != "")
                    report_mismatch(msg);
                if (m_tdata[23:19] !== 5'd0)
                    report_mismatch($sformatf("tdata pad bits %b not zero", m_tdata[23:19]));
            end
        end
    end

    // One pixel transfer; random idle cycles ahead of it in idle phases.
    task automatic send_pixel(input logic [23:0] rgb, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= rgb;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (palette_sb.pending() != 0)
            @(negedge clk);
    endtask

    // One image drawn from a pool of colors. With walk_pool the pool is first sent in order,
    // so a pool wider than the palette fills it and then overflows.
    task automatic send_image(input int unsigned n_pixels, input int unsigned n_colors,
                              input bit walk_pool);
        logic [23:0] shades[$];
        logic [23:0] rgb;
        int unsigned k;
        for (k = 0; k < n_colors; k++)
            shades.push_back(24'($urandom));
        for (k = 0; k < n_pixels; k++)
        begin
            if (walk_pool && k < n_colors)
                rgb = shades[k];
            else if ($urandom_range(99) < 15)
                rgb = 24'($urandom);
            else
                rgb = shades[$urandom_range(n_colors - 1)];
            send_pixel(rgb, k == n_pixels - 1);
        end
    endtask

    // Short random images, mostly reusing a small pool so lookups hit.
    task automatic send_images(input int unsigned n_items);
        int unsigned left;
        int unsigned len;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(1, 40);
            if (len > left)
                len = left;
            send_image(len, $urandom_range(1, 30), 1'b0);
            left -= len;
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: channel extremes, hits, tlast on a hit and on a new color,
        // one-pixel images, and black right after a clear (must be new, not a hit).
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h0000FF, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h808080, 1'b0);
        send_pixel(24'hFF0000, 1'b1);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFF0000, 1'b1);
        send_pixel(24'h010203, 1'b0);
        send_pixel(24'h010203, 1'b0);
        send_pixel(24'h7F7F7F, 1'b1);
        wait_for_results();

        // No idling: a palette overflow image (full palette, hits and misses after it),
        // then short images.
        send_image(300, 270, 1'b1);
        send_images(100);
        wait_for_results();

        // Receiver parks while the sender keeps offering: the chain fills and stalls input.
        hold_request = 1'b1;
        send_image(280, 262, 1'b1);
        wait_for_results();

        send_idle_pct  = 72;
        recv_stall_pct = 0;
        send_images(150);
        wait_for_results();

        send_idle_pct  = 0;
        recv_stall_pct = 72;
        send_images(150);
        wait_for_results();

        send_idle_pct  = 7;
        recv_stall_pct = 7;
        send_images(150);
        wait_for_results();

        // Let anything stray work its way out of the chain.
        recv_stall_pct = 0;
        repeat (PALETTE_ENTRIES + 64) @(negedge clk);
        if (palette_sb.pending() != 0)
            report_mismatch($sformatf("%0d results never arrived", palette_sb.pending()));

        if (mismatch_count == 0)
            $display("exact_color_palette_indexer_top test passed");
        else
            $display("exact_color_palette_indexer_top test failed");
        $finish;
    end

endmodule
